[hw/rtl/lpfp_pkg.sv]
package lpfp_pkg;

	localparam int MAX_CHIPS         = 5;
	localparam int CHANNELS_PER_CHIP = 24;
	localparam int MAX_LEVEL         = 4095;

	localparam int STORE_DEPTH = MAX_CHIPS * CHANNELS_PER_CHIP;
	localparam int PAIR_MAX    = (STORE_DEPTH + 1) / 2;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int ACT_W       = $clog2(STORE_DEPTH + 1);
	localparam int PAIR_W      = $clog2(PAIR_MAX + 1);

	localparam int IN_W   = 16;
	localparam int LVL_W  = 12;
	localparam int CH_W   = IN_W + 2;
	localparam int CC_W   = 3;
	localparam int SLOT_W = 2;
	localparam int WORD_W = 24;
	localparam int CFG_W  = 3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOPERM  = 2'd2;

	typedef enum logic [1:0] {
		ACT_SET_CH  = 2'd0,
		ACT_SET_RGB = 2'd1,
		ACT_FLUSH   = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		CFG_CHIP_COUNT = 2'd0,
		CFG_RED_SLOT   = 2'd1,
		CFG_GREEN_SLOT = 2'd2,
		CFG_BLUE_SLOT  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SEL_SINGLE = 2'd0,
		SEL_RED    = 2'd1,
		SEL_GREEN  = 2'd2,
		SEL_BLUE   = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		RES_SET    = 2'd0,
		RES_NOPERM = 2'd1,
		RES_BADACT = 2'd2,
		RES_PAIR   = 2'd3
	} res_t;

	typedef struct packed {
		logic load;
		logic wr_en;
		sel_t sel;
		logic rd_en;
		logic pair_next;
		logic emit;
		res_t res;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic slots_equal;
		logic pair_last;
	} sts_t;

endpackage

[hw/rtl/lpfp_ctrl.sv]
module lpfp_ctrl import lpfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_WR_S      = 10'b00_0000_0010,
		S_WR_R      = 10'b00_0000_0100,
		S_WR_G      = 10'b00_0000_1000,
		S_WR_B      = 10'b00_0001_0000,
		S_DONE_SET  = 10'b00_0010_0000,
		S_DONE_NOP  = 10'b00_0100_0000,
		S_DONE_BAD  = 10'b00_1000_0000,
		S_FL_RD     = 10'b01_0000_0000,
		S_FL_EMIT   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (act_t'(action))
						ACT_SET_CH:  state_d = S_WR_S;
						ACT_SET_RGB: state_d = sts.slots_equal ? S_DONE_NOP : S_WR_R;
						ACT_FLUSH:   state_d = S_FL_RD;
						default:     state_d = S_DONE_BAD;
					endcase
				end
			end
			S_WR_S: begin
				cmd.wr_en = 1'b1;
				cmd.sel   = SEL_SINGLE;
				state_d   = S_DONE_SET;
			end
			S_WR_R: begin
				cmd.wr_en = 1'b1;
				cmd.sel   = SEL_RED;
				state_d   = S_WR_G;
			end
			S_WR_G: begin
				cmd.wr_en = 1'b1;
				cmd.sel   = SEL_GREEN;
				state_d   = S_WR_B;
			end
			S_WR_B: begin
				cmd.wr_en = 1'b1;
				cmd.sel   = SEL_BLUE;
				state_d   = S_DONE_SET;
			end
			S_DONE_SET: begin
				cmd.emit = 1'b1;
				cmd.res  = RES_SET;
				cmd.last = 1'b1;
				state_d  = S_IDLE;
			end
			S_DONE_NOP: begin
				cmd.emit = 1'b1;
				cmd.res  = RES_NOPERM;
				cmd.last = 1'b1;
				state_d  = S_IDLE;
			end
			S_DONE_BAD: begin
				cmd.emit = 1'b1;
				cmd.res  = RES_BADACT;
				cmd.last = 1'b1;
				state_d  = S_IDLE;
			end
			S_FL_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_FL_EMIT;
			end
			S_FL_EMIT: begin
				cmd.emit      = 1'b1;
				cmd.res       = RES_PAIR;
				cmd.last      = sts.pair_last;
				cmd.pair_next = 1'b1;
				state_d       = sts.pair_last ? S_IDLE : S_FL_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[hw/rtl/lpfp_dp.sv]
module lpfp_dp import lpfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic [IN_W-1:0]   index,
	input  logic [IN_W-1:0]   level_a,
	input  logic [IN_W-1:0]   level_b,
	input  logic [IN_W-1:0]   level_c,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic              done,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] packed_word,
	output logic              last
);

	logic [CC_W-1:0]   chip_count_q;
	logic [SLOT_W-1:0] red_slot_q;
	logic [SLOT_W-1:0] green_slot_q;
	logic [SLOT_W-1:0] blue_slot_q;

	logic [CH_W-1:0]   base_q;
	logic [IN_W-1:0]   idx_q;
	logic [IN_W-1:0]   la_q;
	logic [IN_W-1:0]   lb_q;
	logic [IN_W-1:0]   lc_q;
	logic              err_q;
	logic [PAIR_W-1:0] pair_q;

	logic [LVL_W-1:0]       mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;

	logic [LVL_W-1:0] rd_e_s1;
	logic [LVL_W-1:0] rd_o_s1;
	logic             ev_s1;
	logic             ov_s1;

	logic              done_q;
	logic [1:0]        status_q;
	logic [WORD_W-1:0] word_q;
	logic              last_q;

	logic [CC_W-1:0]   cc_eff;
	logic [ACT_W-1:0]  active;
	logic [ACT_W:0]    pairs;
	logic [CH_W-1:0]   ch;
	logic [IN_W-1:0]   lvl;
	logic              wr_go;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] even_addr;
	logic [PAIR_W:0]   odd_idx;
	logic              odd_ok;
	logic [ADDR_W-1:0] odd_addr;

	// zero chips acts as one, anything past the chain length as the full chain
	always_comb begin
		if (chip_count_q == '0) begin
			cc_eff = CC_W'(1);
		end else if (chip_count_q > CC_W'(MAX_CHIPS)) begin
			cc_eff = CC_W'(MAX_CHIPS);
		end else begin
			cc_eff = chip_count_q;
		end
	end

	assign active = ACT_W'(cc_eff * CHANNELS_PER_CHIP);
	assign pairs  = ((ACT_W + 1)'(active) + (ACT_W + 1)'(1)) >> 1;

	assign sts.slots_equal = (red_slot_q == green_slot_q);
	assign sts.pair_last   = ((ACT_W + 1)'(pair_q) + (ACT_W + 1)'(1)) == pairs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_count_q <= CC_W'(1);
			red_slot_q   <= SLOT_W'(0);
			green_slot_q <= SLOT_W'(1);
			blue_slot_q  <= SLOT_W'(2);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_CHIP_COUNT: chip_count_q <= cfg_wdata;
				CFG_RED_SLOT:   red_slot_q   <= cfg_wdata[SLOT_W-1:0];
				CFG_GREEN_SLOT: green_slot_q <= cfg_wdata[SLOT_W-1:0];
				CFG_BLUE_SLOT:  blue_slot_q  <= cfg_wdata[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// group base index*3 formed once at the start of the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= index;
			base_q <= CH_W'(index) + CH_W'({index, 1'b0});
			la_q   <= level_a;
			lb_q   <= level_b;
			lc_q   <= level_c;
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_SINGLE: begin
				ch  = CH_W'(idx_q);
				lvl = la_q;
			end
			SEL_RED: begin
				ch  = base_q + CH_W'(red_slot_q);
				lvl = la_q;
			end
			SEL_GREEN: begin
				ch  = base_q + CH_W'(green_slot_q);
				lvl = lb_q;
			end
			SEL_BLUE: begin
				ch  = base_q + CH_W'(blue_slot_q);
				lvl = lc_q;
			end
			default: begin
				ch  = CH_W'(idx_q);
				lvl = la_q;
			end
		endcase
	end

	assign wr_go   = cmd.wr_en && (ch < CH_W'(active)) && (lvl <= IN_W'(MAX_LEVEL));
	assign wr_addr = ch[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= 1'b0;
			pair_q <= '0;
			vld_q  <= '0;
		end else begin
			if (cmd.load) begin
				err_q  <= 1'b0;
				pair_q <= '0;
			end else begin
				if (cmd.wr_en && !wr_go) begin
					err_q <= 1'b1;
				end
				if (cmd.pair_next) begin
					pair_q <= pair_q + PAIR_W'(1);
				end
			end
			if (wr_go) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem_q[wr_addr] <= lvl[LVL_W-1:0];
		end
	end

	assign even_addr = ADDR_W'({pair_q, 1'b0});
	assign odd_idx   = {pair_q, 1'b1};
	assign odd_ok    = (ADDR_W + 1)'(odd_idx) < (ADDR_W + 1)'(active);
	assign odd_addr  = odd_ok ? ADDR_W'(odd_idx) : even_addr;

	// never-written entries read back as zero through the valid bits
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_e_s1 <= mem_q[even_addr];
			rd_o_s1 <= mem_q[odd_addr];
			ev_s1   <= vld_q[even_addr];
			ov_s1   <= odd_ok && vld_q[odd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q <= cmd.last;
			case (cmd.res)
				RES_SET: begin
					status_q <= err_q ? ST_INVALID : ST_OK;
					word_q   <= '0;
				end
				RES_NOPERM: begin
					status_q <= ST_NOPERM;
					word_q   <= '0;
				end
				RES_BADACT: begin
					status_q <= ST_INVALID;
					word_q   <= '0;
				end
				RES_PAIR: begin
					// even low byte, even high nibble, odd low nibble, odd high byte
					status_q <= ST_OK;
					word_q   <= {(ov_s1 ? rd_o_s1 : LVL_W'(0)), (ev_s1 ? rd_e_s1 : LVL_W'(0))};
				end
				default: begin
					status_q <= ST_INVALID;
					word_q   <= '0;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign packed_word = word_q;
	assign last        = last_q;

endmodule

[hw/rtl/led_pwm_frame_packer_unit.sv]
// channel   | signals                                        | handshake
// ----------+------------------------------------------------+----------------------------
// command   | action, index, level_a, level_b, level_c       | start, taken when !busy
// result    | status, packed_word, last                      | done, one cycle, no stall
// config    | cfg_addr, cfg_wdata                            | cfg_we, registered write
//
// set channel keeps busy through a write and a done state, RGB group through three writes
// (single write port of the level store) and a done state, wiring-not-permitted and
// unknown action a done state. flush: registered dual read, then pack, ceil(n/2) words.
// each result strobes done in the cycle after the block leaves the item's last state.
// reset clears config to defaults and all level valid bits, so the store reads zero.
// results cannot be held off by the receiver; there is no output stall.
module led_pwm_frame_packer_unit import lpfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [IN_W-1:0]   index,
	input  logic [IN_W-1:0]   level_a,
	input  logic [IN_W-1:0]   level_b,
	input  logic [IN_W-1:0]   level_c,
	output logic              done,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] packed_word,
	output logic              last,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	lpfp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lpfp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.index       (index),
		.level_a     (level_a),
		.level_b     (level_b),
		.level_c     (level_c),
		.cmd         (cmd),
		.sts         (sts),
		.done        (done),
		.status      (status),
		.packed_word (packed_word),
		.last        (last)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not make the block busy");

	a_more_words: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy)
		else $error("non-final flush word while controller idle");

	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> last && (packed_word == '0))
		else $error("error status on a non-final or nonzero result");

endmodule
